/* rtl/message_frame_deframer_macros.svh */
// Assertion macros shared by the deframer modules.
`ifndef MESSAGE_FRAME_DEFRAMER_MACROS_SVH
`define MESSAGE_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside reset.
`define MFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define MFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/mfd_pkg.sv */
package mfd_pkg;

    // Number of payload bytes per frame that are passed on.
    localparam int PAYLOAD_CAPACITY = 256;
    localparam logic [15:0] CAP_LEN = 16'(PAYLOAD_CAPACITY);
    localparam logic [16:0] CAP_WIDE = 17'(PAYLOAD_CAPACITY);

    // Parser phase, one-hot.
    typedef enum logic [3:0] {
        PH_CMD = 4'b0001,
        PH_ID  = 4'b0010,
        PH_LEN = 4'b0100,
        PH_PAY = 4'b1000
    } phase_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  command;
        logic [15:0] msg_id;
        logic [15:0] msg_length;
        logic        is_payload;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic        frame_done;
    } res_t;

endpackage

/* rtl/message_frame_deframer.sv */
// A byte is accepted into the input register; the parser takes it from there and
// registers any result in the result register, one parser step per byte.
// Throughput: one byte per cycle unless out_stall holds a waiting result.
// A waiting result that is stalled holds the input register, so in_stall follows
// out_stall in the same cycle while both registers are full.
// Reset restarts the parser, clears both valid flags and zeroes resp_reg.
module message_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  response_code,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  command,
    output logic [15:0] msg_id,
    output logic [15:0] msg_length,
    output logic        is_payload,
    output logic [7:0]  data_byte,
    output logic [7:0]  byte_index,
    output logic        frame_done
);

    logic          cfg_write;
    logic [7:0]    resp_reg;
    logic          blocked;
    logic          fire;
    logic [7:0]    stage_byte;
    logic          has_result;
    mfd_pkg::res_t res;
    mfd_pkg::res_t res_out;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            resp_reg <= response_code;
        end
    end

    // Input register.
    mfd_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .blocked  (blocked),
        .fire     (fire),
        .byte_out (stage_byte)
    );

    // Frame parser.
    mfd_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .rx_byte       (stage_byte),
        .response_code (resp_reg),
        .has_result    (has_result),
        .res           (res)
    );

    // Result register.
    mfd_result_reg u_res
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .has_result (has_result),
        .res_in     (res),
        .out_stall  (out_stall),
        .blocked    (blocked),
        .out_valid  (out_valid),
        .res_out    (res_out)
    );

    assign command    = res_out.command;
    assign msg_id     = res_out.msg_id;
    assign msg_length = res_out.msg_length;
    assign is_payload = res_out.is_payload;
    assign data_byte  = res_out.data_byte;
    assign byte_index = res_out.byte_index;
    assign frame_done = res_out.frame_done;

endmodule

/* rtl/mfd_in_stage.sv */
`include "message_frame_deframer_macros.svh"

module mfd_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       blocked,
    output logic       fire,
    output logic [7:0] byte_out
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // The register is refilled unless it holds a request the parser cannot take.
    assign in_stall = valid_reg && blocked;
    assign fire     = valid_reg && !blocked;
    assign byte_out = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                byte_next = rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // A held request keeps its byte until the parser takes it.
    `MFD_ASSERT_NEXT(a_in_hold, clk, rst_n, valid_reg && blocked, valid_reg && $stable(byte_reg), "input stage lost a held request")

endmodule

/* rtl/mfd_parser.sv */
`include "message_frame_deframer_macros.svh"

module mfd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        response_code,
    output logic              has_result,
    output mfd_pkg::res_t     res
);

    mfd_pkg::phase_t phase_reg;
    mfd_pkg::phase_t phase_next;
    logic [15:0]     count_reg;
    logic [15:0]     count_next;
    logic [7:0]      cmd_reg;
    logic [7:0]      cmd_next;
    logic [15:0]     id_reg;
    logic [15:0]     id_next;
    logic [15:0]     len_reg;
    logic [15:0]     len_next;
    logic [16:0]     idx_plus;
    logic            stored;
    logic            done;

    // Payload position tests.
    assign idx_plus = {1'b0, count_reg} + 17'd1;
    assign stored   = {1'b0, count_reg} < mfd_pkg::CAP_WIDE;
    assign done     = idx_plus >= {1'b0, len_reg};

    // Next state and the result caused by the current byte.
    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        has_result     = 1'b0;
        res.command    = cmd_reg;
        res.msg_id     = id_reg;
        res.msg_length = len_reg;
        res.is_payload = 1'b0;
        res.data_byte  = 8'd0;
        res.byte_index = 8'd0;
        res.frame_done = 1'b0;
        case (phase_reg)
            mfd_pkg::PH_CMD:
            begin
                cmd_next   = rx_byte;
                count_next = 16'd0;
                phase_next = mfd_pkg::PH_ID;
            end
            mfd_pkg::PH_ID:
            begin
                id_next = {id_reg[7:0], rx_byte};
                if (count_reg[0])
                begin
                    count_next = 16'd0;
                    phase_next = mfd_pkg::PH_LEN;
                end
                else
                begin
                    count_next = 16'd1;
                end
            end
            mfd_pkg::PH_LEN:
            begin
                len_next = {len_reg[7:0], rx_byte};
                if (!count_reg[0])
                begin
                    count_next = 16'd1;
                end
                else
                begin
                    count_next = 16'd0;
                    if (cmd_reg != response_code && len_next != 16'd0)
                    begin
                        phase_next = mfd_pkg::PH_PAY;
                    end
                    else
                    begin
                        // Response or empty frame ends with its header.
                        phase_next     = mfd_pkg::PH_CMD;
                        has_result     = 1'b1;
                        res.msg_length = len_next;
                        res.frame_done = 1'b1;
                    end
                end
            end
            mfd_pkg::PH_PAY:
            begin
                count_next     = count_reg + 16'd1;
                has_result     = stored || done;
                res.is_payload = stored;
                res.data_byte  = stored ? rx_byte : 8'd0;
                res.byte_index = stored ? count_reg[7:0] : 8'd0;
                res.frame_done = done;
                if (done)
                begin
                    // The done result reports the length clipped to the capacity.
                    if ({1'b0, len_reg} > mfd_pkg::CAP_WIDE)
                    begin
                        len_next = mfd_pkg::CAP_LEN;
                    end
                    res.msg_length = len_next;
                    phase_next     = mfd_pkg::PH_CMD;
                    count_next     = 16'd0;
                end
            end
            default:
            begin
                phase_next = mfd_pkg::PH_CMD;
                count_next = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mfd_pkg::PH_CMD;
            count_reg <= 16'd0;
            cmd_reg   <= 8'd0;
            id_reg    <= 16'd0;
            len_reg   <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            cmd_reg   <= cmd_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
        end
    end

    // Header fields count at most two bytes.
    `MFD_ASSERT(a_hdr_count, clk, rst_n, phase_reg == mfd_pkg::PH_PAY || count_reg <= 16'd1, "header byte count out of range")
    // Payload results come only from the payload phase.
    `MFD_ASSERT(a_pay_phase, clk, rst_n, !(has_result && res.is_payload) || phase_reg == mfd_pkg::PH_PAY, "payload result outside payload phase")
    // A command byte always moves the parser to the id field.
    `MFD_ASSERT_NEXT(a_cmd_to_id, clk, rst_n, fire && phase_reg == mfd_pkg::PH_CMD, phase_reg == mfd_pkg::PH_ID, "command byte did not advance to id")

endmodule

/* rtl/mfd_result_reg.sv */
`include "message_frame_deframer_macros.svh"

module mfd_result_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic          has_result,
    input  mfd_pkg::res_t res_in,
    input  logic          out_stall,
    output logic          blocked,
    output logic          out_valid,
    output mfd_pkg::res_t res_out
);

    logic          valid_reg;
    logic          valid_next;
    mfd_pkg::res_t data_reg;
    mfd_pkg::res_t data_next;

    // The register is held only while its request waits downstream.
    assign blocked   = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign res_out   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (!blocked)
        begin
            valid_next = fire && has_result;
            if (fire && has_result)
            begin
                data_next = res_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Every delivered request carries a payload byte or ends a frame.
    `MFD_ASSERT(a_res_kind, clk, rst_n, !valid_reg || data_reg.is_payload || data_reg.frame_done, "empty result delivered")
    // Data and index are zero on a result without a payload byte.
    `MFD_ASSERT(a_res_zero, clk, rst_n, !valid_reg || data_reg.is_payload || (data_reg.data_byte == 8'd0 && data_reg.byte_index == 8'd0), "stray data on done result")

endmodule

/* test/message_frame_deframer_tb.sv */
module message_frame_deframer_tb;

    // Cycles without any accepted request before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;
    // Cycles allowed for a byte to travel through the block.
    localparam int PIPE_CYCLES = 4;
    localparam int TOTAL_BYTES = 1300;
    localparam int NUM_PHASES = 6;

    // Tracks the frame parser and compares every result with the prediction.
    class frame_checker;
        mfd_pkg::res_t   pending_results[$];
        mfd_pkg::phase_t ph;
        logic [15:0]     field_count;
        logic [7:0]      cur_cmd;
        logic [15:0]     cur_id;
        logic [15:0]     cur_len;
        logic [7:0]      resp_code;
        int              errors;
        int              checked;
        int              payload_seen;
        int              done_seen;

        function new();
            ph = mfd_pkg::PH_CMD;
            field_count = '0;
            cur_cmd = '0;
            cur_id = '0;
            cur_len = '0;
            resp_code = '0;
            errors = 0;
            checked = 0;
            payload_seen = 0;
            done_seen = 0;
        endfunction

        function void set_code(logic [7:0] v);
            resp_code = v;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Advance the parser by one accepted byte and queue any result it causes.
        function void parse_byte(logic [7:0] b);
            int            idx;
            bit            stored;
            bit            done;
            logic [15:0]   out_len;
            mfd_pkg::res_t r;
            case (ph)
                mfd_pkg::PH_CMD:
                begin
                    cur_cmd = b;
                    field_count = '0;
                    ph = mfd_pkg::PH_ID;
                end
                mfd_pkg::PH_ID:
                begin
                    cur_id = {cur_id[7:0], b};
                    field_count = field_count + 16'd1;
                    if (field_count >= 16'd2)
                    begin
                        field_count = '0;
                        ph = mfd_pkg::PH_LEN;
                    end
                end
                mfd_pkg::PH_LEN:
                begin
                    cur_len = {cur_len[7:0], b};
                    field_count = field_count + 16'd1;
                    if (field_count >= 16'd2)
                    begin
                        field_count = '0;
                        if (cur_cmd != resp_code && cur_len != 16'd0)
                            ph = mfd_pkg::PH_PAY;
                        else
                        begin
                            // Response or empty frame ends right after the header.
                            ph = mfd_pkg::PH_CMD;
                            r.command = cur_cmd;
                            r.msg_id = cur_id;
                            r.msg_length = cur_len;
                            r.is_payload = 1'b0;
                            r.data_byte = '0;
                            r.byte_index = '0;
                            r.frame_done = 1'b1;
                            pending_results.push_back(r);
                        end
                    end
                end
                default:
                begin
                    idx = int'(field_count);
                    stored = idx < mfd_pkg::PAYLOAD_CAPACITY;
                    field_count = field_count + 16'd1;
                    done = (idx + 1) >= int'(cur_len);
                    out_len = cur_len;
                    if (done)
                    begin
                        // The done result reports the length clipped to the capacity.
                        if (int'(cur_len) > mfd_pkg::PAYLOAD_CAPACITY)
                            cur_len = mfd_pkg::CAP_LEN;
                        out_len = cur_len;
                        ph = mfd_pkg::PH_CMD;
                        field_count = '0;
                    end
                    if (stored || done)
                    begin
                        r.command = cur_cmd;
                        r.msg_id = cur_id;
                        r.msg_length = out_len;
                        r.is_payload = stored;
                        r.data_byte = stored ? b : 8'd0;
                        r.byte_index = stored ? idx[7:0] : 8'd0;
                        r.frame_done = done;
                        pending_results.push_back(r);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(mfd_pkg::res_t got);
            mfd_pkg::res_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (want.is_payload)
                payload_seen++;
            if (want.frame_done)
                done_seen++;
            compare_field("command", 16'(want.command), 16'(got.command));
            compare_field("msg_id", want.msg_id, got.msg_id);
            compare_field("msg_length", want.msg_length, got.msg_length);
            compare_field("is_payload", 16'(want.is_payload), 16'(got.is_payload));
            compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
            compare_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
            compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  response_code;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  command;
    logic [15:0] msg_id;
    logic [15:0] msg_length;
    logic        is_payload;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        frame_done;

    frame_checker  chk;
    mfd_pkg::res_t seen;
    logic [7:0]    active_code;
    bit            tx_calm;
    bit            rx_calm;
    int            bytes_sent;
    int            frames_sent;
    int            response_frames;
    int            overflow_frames;
    int            code_writes;

    message_frame_deframer DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .response_code (response_code),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .command       (command),
        .msg_id        (msg_id),
        .msg_length    (msg_length),
        .is_payload    (is_payload),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .frame_done    (frame_done)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Watch both channels and feed the checker at every edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                chk.parse_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                seen.command = command;
                seen.msg_id = msg_id;
                seen.msg_length = msg_length;
                seen.is_payload = is_payload;
                seen.data_byte = data_byte;
                seen.byte_index = byte_index;
                seen.frame_done = frame_done;
                chk.check_result(seen);
            end
        end
    end

    // Abort when no request moves on any channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                          (cfg_valid && cfg_ready)))
                quiet = 0;
            else
                quiet++;
        end
        $display("message_frame_deframer_tb: FAIL");
        $finish;
    end

    // Result side: random stall before each result, with calm stretches.
    initial
    begin : result_sink
        int hold;
        out_stall <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                rx_calm = !rx_calm;
            hold = rx_calm ? 0 : $urandom_range(0, 16);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Offer one byte after a random gap and return at the edge that takes it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Hold off input until every predicted result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk.pending() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    // Change the response code while the block is idle.
    task automatic write_code(input logic [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        response_code <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        chk.set_code(v);
        active_code = v;
        code_writes++;
    endtask

    task automatic send_header(input logic [7:0] c, input logic [15:0] id,
                               input logic [15:0] len);
        frames_sent++;
        if (c == active_code)
            response_frames++;
        else if (int'(len) > mfd_pkg::PAYLOAD_CAPACITY)
            overflow_frames++;
        send_byte(c);
        send_byte(id[15:8]);
        send_byte(id[7:0]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    // Whole frame with random payload; payload only follows a non-response header.
    task automatic send_frame(input logic [7:0] c, input logic [15:0] id,
                              input logic [15:0] len);
        int k;
        int pick;
        send_header(c, id, len);
        if (c != active_code)
        begin
            for (k = 0; k < int'(len); k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    send_byte(8'h00);
                else if (pick == 1)
                    send_byte(8'hFF);
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // One random frame: mostly short data frames, plus responses, empty frames,
    // frames around the capacity and unconstrained headers.
    task automatic send_random_frame();
        int          r;
        logic [7:0]  c;
        logic [15:0] id;
        logic [15:0] len;
        r = $urandom_range(0, 99);
        id = 16'($urandom);
        c = 8'($urandom_range(0, 255));
        if (c == active_code)
            c = c ^ 8'h01;
        if ($urandom_range(0, 5) == 0)
            tx_calm = !tx_calm;
        if ($urandom_range(0, 19) == 0)
            drain();
        if (frames_sent % 23 == 11)
        begin
            case ($urandom_range(0, 3))
                0: len = 16'd255;
                1: len = 16'd256;
                2: len = 16'd257;
                default: len = 16'($urandom_range(258, 300));
            endcase
        end
        else if (r < 25)
        begin
            c = active_code;
            len = 16'($urandom);
        end
        else if (r < 33)
            len = 16'd0;
        else if (r < 43)
        begin
            c = ($urandom_range(0, 1) == 0) ? active_code : 8'($urandom_range(0, 255));
            len = (c == active_code) ? 16'($urandom) : 16'($urandom_range(0, 40));
        end
        else
            len = 16'($urandom_range(1, 24));
        send_frame(c, id, len);
    endtask

    // Main sequence: reset, directed frames, then random phases per response code.
    initial
    begin
        int p;
        int stop_at;
        logic [7:0] phase_codes [NUM_PHASES];
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        response_code <= 8'h00;
        in_valid <= 1'b0;
        rx_byte <= 8'h00;
        chk = new();
        active_code = 8'h00;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        bytes_sent = 0;
        frames_sent = 0;
        response_frames = 0;
        overflow_frames = 0;
        code_writes = 0;
        phase_codes[0] = 8'hFF;
        phase_codes[1] = 8'($urandom_range(1, 254));
        phase_codes[2] = 8'h00;
        phase_codes[3] = 8'($urandom_range(0, 255));
        phase_codes[4] = 8'h80;
        phase_codes[5] = 8'($urandom_range(0, 255));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset response code of zero.
        send_header(8'h00, 16'hFFFF, 16'hFFFF);
        send_header(8'hFF, 16'h0000, 16'h0000);
        send_header(8'h5A, 16'h1234, 16'h0001);
        send_byte(8'hFF);
        send_header(8'hA5, 16'h8001, 16'h0003);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_header(8'h00, 16'h00FF, 16'h0000);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_code(phase_codes[p]);
            stop_at = bytes_sent + TOTAL_BYTES / NUM_PHASES;
            while (bytes_sent < stop_at)
                send_random_frame();
        end

        drain();
        repeat (PIPE_CYCLES) @(posedge clk);
        $display("Sent %0d bytes in %0d frames (%0d responses, %0d past capacity).",
                 bytes_sent, frames_sent, response_frames, overflow_frames);
        $display("Checked %0d results: %0d payload bytes, %0d frames, %0d code writes.",
                 chk.checked, chk.payload_seen, chk.done_seen, code_writes);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("message_frame_deframer_tb: PASS");
        else
            $display("message_frame_deframer_tb: FAIL");
        $finish;
    end

endmodule
